FILE: hdl/knnws_pkg.sv
// ============================================================================
// knnws_pkg: shared types and constants of the kNN weighted candidate sampler
// Holds command codes, the controller-to-datapath command struct and sizes.
// ============================================================================
package knnws_pkg;

	localparam int MAX_CANDIDATES_DEF = 256;
	localparam int DIST_W = 32;
	localparam int DAY_W = 16;
	localparam int WEIGHT_W = 40;
	localparam int KMAX_DEF = 17;

	typedef enum logic [1:0] {
		CMD_ACCUM = 2'd0,
		CMD_DRAW  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// controller commands to the datapath
	typedef struct packed {
		logic accum;      // consume accumulate item
		logic clear;      // empty the pool
		logic take_r;     // latch the draw fraction
		logic sort_cmp;   // compare/swap i,j
		logic sqrt_start;
		logic div_start;  // start reciprocal of entry i
		logic div_rd;     // read entry i for weight
		logic tbl_wr;     // store weight for entry i
		logic srch_rd;    // read cumulative entry i
		logic set_sorted;
		logic i_clr;
		logic i_inc;
		logic j_set;      // j = i + 1
		logic j_inc;
	} ctl_t;

	// datapath status to the controller
	typedef struct packed {
		logic small_pool;
		logic sorted;
		logic j_last;     // j == n-1
		logic i_last_sort;// i + 2 >= n
		logic sqrt_done;
		logic div_done;
		logic i_last_k;   // i == k-1
		logic hit;        // search condition met
	} stat_t;

endpackage

FILE: hdl/knn_weighted_candidate_sampler_top.sv
// ============================================================================
// knn_weighted_candidate_sampler_top: kNN inverse-distance candidate sampler
// Accumulate commands are handled in the idle state. A draw after the pool
// changed sorts the pool by pairwise exchange (n(n-1)/2 pairs, each taken
// through S_SRD, S_SWAIT, S_SCMP and S_SWB), finds k = floor(sqrt(n))+1 by
// counting, forms k reciprocals on a bit-serial divider and searches the
// cumulative table through S_FRD, S_FM1 and S_FM2 per entry; a draw on a
// sorted pool skips the sort but rebuilds the table. The pool memory needs
// no clearing pass.
// ============================================================================
module knn_weighted_candidate_sampler_top #(
	parameter int MAX_CANDIDATES = knnws_pkg::MAX_CANDIDATES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] cand_day,
	input  logic [15:0] target_rain,
	input  logic [15:0] cand_rain,
	input  logic        last_of_candidate,
	input  logic [15:0] random_fraction,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] chosen_day,
	output logic        status
);
	knnws_pkg::ctl_t  ctl;
	knnws_pkg::stat_t stat;
	logic [15:0]      pick_day;

	knnws_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.command(command), .out_valid(out_valid), .out_ready(out_ready),
		.status(status), .chosen_day(chosen_day), .pick_day(pick_day),
		.stat(stat), .ctl(ctl)
	);

	knnws_datapath #(.MAX_CANDIDATES(MAX_CANDIDATES)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .cand_day(cand_day),
		.target_rain(target_rain), .cand_rain(cand_rain),
		.last_of_candidate(last_of_candidate), .random_fraction(random_fraction),
		.stat(stat), .pick_day(pick_day)
	);
endmodule

FILE: hdl/knnws_ram.sv
// ============================================================================
// knnws_ram: generic single-write, dual-read RAM with registered read data
// ============================================================================
module knnws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule

FILE: hdl/knnws_div.sv
// ============================================================================
// knnws_div: restoring divider, 2^32 / d, one quotient bit per cycle
// ============================================================================
module knnws_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [32:0] quotient
);
	logic [32:0] rem_q;
	logic [32:0] quo_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [33:0] trial;

	// numerator is 1 followed by 32 zeros: bit 32 enters first
	assign trial = {rem_q, (cnt_q == 6'd32)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			dvs_q <= (divisor == 32'd0) ? 32'd1 : divisor;
		end else if (busy_q) begin
			if (trial >= {2'b00, dvs_q}) begin
				rem_q <= 33'(trial - {2'b00, dvs_q});
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

FILE: hdl/knnws_datapath.sv
// ============================================================================
// knnws_datapath: pool memories, distance accumulator, sort, weights, search
// Acts on controller commands; reports status bits back.
// ============================================================================
module knnws_datapath #(
	parameter int MAX_CANDIDATES = knnws_pkg::MAX_CANDIDATES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  knnws_pkg::ctl_t     ctl,
	input  logic [15:0]         cand_day,
	input  logic [15:0]         target_rain,
	input  logic [15:0]         cand_rain,
	input  logic                last_of_candidate,
	input  logic [15:0]         random_fraction,
	output knnws_pkg::stat_t    stat,
	output logic [15:0]         pick_day
);
	// largest kept count, floor(sqrt(n)) + 1 for a full pool
	function automatic int kmax_of(int n);
		int s;
		s = 0;
		while ((s + 1) * (s + 1) <= n)
			s++;
		return s + 1;
	endfunction

	localparam int KMAX = kmax_of(MAX_CANDIDATES);
	localparam int AW = $clog2(MAX_CANDIDATES);
	localparam int CW = $clog2(MAX_CANDIDATES + 1);
	localparam int KW = $clog2(KMAX + 1);
	localparam int TW = $clog2(KMAX);
	localparam int EW = knnws_pkg::DIST_W + knnws_pkg::DAY_W;

	logic [CW-1:0] count_q;
	logic [31:0]   run_q;
	logic          sorted_q;
	logic [CW-1:0] i_q, j_q;
	logic [KW-1:0] k_q;
	logic [15:0]   sq_q;
	logic [15:0]   r_q;
	logic [knnws_pkg::WEIGHT_W-1:0] acc_q, total_q;
	logic [knnws_pkg::WEIGHT_W-1:0] cum_q [KMAX];
	logic [knnws_pkg::WEIGHT_W-1:0] cum_rd_q;

	// pool memory, entry = {distance, day}
	logic          we;
	logic [AW-1:0] waddr, ra, rb;
	logic [EW-1:0] wdata, rda, rdb;
	logic          swap_hi_q;

	logic [16:0] diff;
	logic [32:0] sum;
	logic        div_done;
	logic [32:0] quo;

	assign diff = (target_rain > cand_rain) ? {1'b0, target_rain} - {1'b0, cand_rain}
		: {1'b0, cand_rain} - {1'b0, target_rain};
	assign sum = {1'b0, run_q} + {16'd0, diff};

	// look ahead on advance so the registered read follows the new index
	assign ra = AW'(ctl.i_inc ? i_q + CW'(1) : i_q);
	assign rb = AW'(j_q);

	knnws_ram #(.WIDTH(EW), .DEPTH(MAX_CANDIDATES)) u_pool (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(ra), .raddr_b(rb), .rdata_a(rda), .rdata_b(rdb)
	);

	knnws_div u_div (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_start),
		.divisor(rda[EW-1:knnws_pkg::DAY_W]), .done(div_done), .quotient(quo)
	);

	// a swap writes twice: i gets b in sort_cmp, j gets a the next cycle
	logic [EW-1:0] hold_q;
	always_comb begin
		we    = 1'b0;
		waddr = AW'(count_q);
		wdata = {sum[32] ? 32'hFFFF_FFFF : sum[31:0], cand_day};
		if (ctl.accum && last_of_candidate && count_q < CW'(MAX_CANDIDATES)) begin
			we = 1'b1;
		end else if (ctl.sort_cmp && rda[EW-1:16] > rdb[EW-1:16]) begin
			we = 1'b1; waddr = AW'(i_q); wdata = rdb;
		end else if (swap_hi_q) begin
			we = 1'b1; waddr = AW'(j_q); wdata = hold_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sort_cmp) begin
			hold_q <= rda;
		end
		if (ctl.div_start) begin
			acc_q <= (i_q == '0) ? '0 : acc_q;
		end
		if (ctl.tbl_wr) begin
			cum_q[TW'(i_q)] <= acc_q + knnws_pkg::WEIGHT_W'(quo);
			acc_q <= acc_q + knnws_pkg::WEIGHT_W'(quo);
			total_q <= acc_q + knnws_pkg::WEIGHT_W'(quo);
		end
		if (ctl.take_r) begin
			r_q <= random_fraction;
		end
		if (ctl.srch_rd) begin
			cum_rd_q <= cum_q[TW'(i_q)];
		end
	end

	// exact threshold compare, split into a product stage
	logic [56:0] lhs_s1, rhs_s1;
	always_ff @(posedge clk) begin
		lhs_s1 <= 57'(cum_rd_q) * 57'd65535;
		rhs_s1 <= 57'(r_q) * 57'(total_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			run_q     <= '0;
			sorted_q  <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			sq_q      <= '0;
			swap_hi_q <= 1'b0;
		end else begin
			swap_hi_q <= ctl.sort_cmp && (rda[EW-1:16] > rdb[EW-1:16]);
			if (ctl.accum) begin
				if (last_of_candidate) begin
					run_q <= '0;
					sorted_q <= 1'b0;
					if (count_q < CW'(MAX_CANDIDATES)) begin
						count_q <= count_q + CW'(1);
					end
				end else begin
					run_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				end
			end
			if (ctl.clear) begin
				count_q <= '0; run_q <= '0; sorted_q <= 1'b0;
			end
			if (ctl.set_sorted) sorted_q <= 1'b1;
			if (ctl.i_clr) i_q <= '0;
			else if (ctl.i_inc) i_q <= i_q + CW'(1);
			if (ctl.j_set) begin
				j_q <= ctl.i_clr ? CW'(1) : ((ctl.i_inc) ? i_q + CW'(2) : i_q + CW'(1));
			end else if (ctl.j_inc) j_q <= j_q + CW'(1);
			// integer sqrt by counting up until (sq + 1)^2 exceeds n
			if (ctl.sqrt_start) begin
				sq_q <= '0;
			end else if (!stat.sqrt_done) begin
				sq_q <= sq_q + 16'd1;
			end
			if (ctl.sqrt_start || ctl.clear) k_q <= '0;
			else if (stat.sqrt_done && k_q == '0) begin
				k_q <= (32'(sq_q) + 32'd1 > 32'(count_q)) ? KW'(count_q)
					: KW'(sq_q + 16'd1);
			end
		end
	end

	logic [31:0] sqn;
	assign sqn = (32'(sq_q) + 32'd1) * (32'(sq_q) + 32'd1);

	assign stat.small_pool  = count_q < CW'(2);
	assign stat.sorted      = sorted_q;
	assign stat.j_last      = (j_q + CW'(1) >= count_q);
	assign stat.i_last_sort = (i_q + CW'(2) >= count_q);
	assign stat.sqrt_done   = sqn > 32'(count_q);
	assign stat.div_done    = div_done;
	assign stat.i_last_k    = (i_q + CW'(1) >= CW'(k_q));
	assign stat.hit         = lhs_s1 >= rhs_s1;
	assign pick_day         = rda[15:0];
endmodule

FILE: hdl/knnws_ctrl.sv
// ============================================================================
// knnws_ctrl: sequencer for accumulate, clear, sort, weight build and search
// ============================================================================
module knnws_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic [15:0]        chosen_day,
	input  logic [15:0]        pick_day,
	input  knnws_pkg::stat_t   stat,
	output knnws_pkg::ctl_t    ctl
);
	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_SRD   = 13'b0000000000010,
		S_SWAIT = 13'b0000000000100,
		S_SCMP  = 13'b0000000001000,
		S_SWB   = 13'b0000000010000,
		S_SQRT  = 13'b0000000100000,
		S_DRD   = 13'b0000001000000,
		S_DIV   = 13'b0000010000000,
		S_FRD   = 13'b0000100000000,
		S_FM1   = 13'b0001000000000,
		S_FM2   = 13'b0010000000000,
		S_PICK  = 13'b0100000000000,
		S_PWAIT = 13'b1000000000000
	} state_t;

	state_t st_q;
	logic   ovalid_q;
	logic   go;

	assign in_ready  = (st_q == S_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;
	assign go        = in_valid && in_ready;

	always_comb begin
		ctl = '0;
		if (go) begin
			ctl.accum = (command == knnws_pkg::CMD_ACCUM);
			ctl.clear = (command == knnws_pkg::CMD_CLEAR);
			if (command == knnws_pkg::CMD_DRAW && !stat.small_pool) begin
				ctl.take_r = 1'b1;
				ctl.i_clr = 1'b1;
				ctl.j_set = 1'b1;
				ctl.sqrt_start = stat.sorted;
			end
		end
		unique case (st_q)
			S_IDLE: ;
			S_SRD: ;
			S_SWAIT: ;
			S_SCMP: ctl.sort_cmp = 1'b1;
			S_SWB: begin
				if (stat.j_last) begin
					if (stat.i_last_sort) begin
						ctl.sqrt_start = 1'b1;
						ctl.i_clr = 1'b1;
					end else begin
						ctl.i_inc = 1'b1;
						ctl.j_set = 1'b1;
					end
				end else begin
					ctl.j_inc = 1'b1;
				end
			end
			S_SQRT: ;
			S_DRD: ;
			S_DIV: begin
				if (stat.div_done) begin
					ctl.tbl_wr = 1'b1;
					if (stat.i_last_k) begin
						ctl.set_sorted = 1'b1;
						ctl.i_clr = 1'b1;
					end else begin
						ctl.i_inc = 1'b1;
					end
				end
			end
			S_FRD: ctl.srch_rd = 1'b1;
			S_FM1: ;
			S_FM2: begin
				if (!stat.hit && !stat.i_last_k) ctl.i_inc = 1'b1;
			end
			S_PICK: ;
			S_PWAIT: ;
			default: ;
		endcase
		if (st_q == S_DRD) begin
			ctl.div_start = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			ovalid_q   <= 1'b0;
			status     <= 1'b0;
			chosen_day <= '0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (go && command == knnws_pkg::CMD_DRAW) begin
						if (stat.small_pool) begin
							ovalid_q <= 1'b1; status <= 1'b1; chosen_day <= '0;
						end else if (stat.sorted) begin
							st_q <= S_SQRT;
						end else begin
							st_q <= S_SRD;
						end
					end
				end
				S_SRD:   st_q <= S_SWAIT;
				S_SWAIT: st_q <= S_SCMP;
				S_SCMP:  st_q <= S_SWB;
				S_SWB:   st_q <= (stat.j_last && stat.i_last_sort) ? S_SQRT : S_SRD;
				S_SQRT:  if (stat.sqrt_done) st_q <= S_DRD;
				S_DRD:   st_q <= S_DIV;
				S_DIV: begin
					if (stat.div_done) st_q <= stat.i_last_k ? S_FRD : S_DRD;
				end
				S_FRD:   st_q <= S_FM1;
				S_FM1:   st_q <= S_FM2;
				S_FM2:   st_q <= (stat.hit || stat.i_last_k) ? S_PICK : S_FRD;
				S_PICK:  st_q <= S_PWAIT;
				S_PWAIT: begin
					ovalid_q <= 1'b1; status <= 1'b0; chosen_day <= pick_day;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: hdl/knnws_checker.sv
// ============================================================================
// knnws_checker: port-level checks of the sampler
// ============================================================================
module knnws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] chosen_day,
	input logic        status
);
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> chosen_day == 16'd0) else $error("error result carries a day");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(chosen_day)) else $error("result dropped");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("accept while result waits");
endmodule

bind knn_weighted_candidate_sampler_top knnws_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.chosen_day(chosen_day), .status(status)
);
